### hdl/aqi_pkg.sv
// Shared types and breakpoint tables for the particulate AQI interpolator.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package aqi_pkg;

    localparam int ROWS   = 7;
    localparam int ROW_W  = 3;
    localparam int BP_W   = 13;
    localparam int IDX_W  = 9;
    localparam int DI_W   = 7;
    localparam int OFF_W  = 11;
    localparam int NUM_W  = DI_W + OFF_W;
    localparam int RCP_W  = 22;
    localparam int PROD_W = NUM_W + RCP_W;
    localparam int SHIFT  = 29;
    localparam int Q_W    = 7;

    localparam logic [IDX_W-1:0] TOP_INDEX = IDX_W'(500);

    localparam bit TAB_PM25 = 1'b0;
    localparam bit TAB_PM10 = 1'b1;

    // lo breakpoint, lo index, index span, ceil(2^SHIFT / breakpoint span)
    typedef struct packed {
        logic [BP_W-1:0]  lo;
        logic [IDX_W-1:0] ilo;
        logic [DI_W-1:0]  di;
        logic [RCP_W-1:0] rcp;
    } t_seg;

    typedef t_seg t_tab [ROWS];

    typedef struct packed {
        logic [IDX_W-1:0] pm25;
        logic [IDX_W-1:0] pm10;
    } t_idx_pair;

    localparam t_tab PM25_TAB = '{
        '{lo: BP_W'(0),    ilo: IDX_W'(0),   di: DI_W'(50), rcp: RCP_W'(2147484)},
        '{lo: BP_W'(251),  ilo: IDX_W'(51),  di: DI_W'(49), rcp: RCP_W'(2156109)},
        '{lo: BP_W'(501),  ilo: IDX_W'(101), di: DI_W'(49), rcp: RCP_W'(1795555)},
        '{lo: BP_W'(801),  ilo: IDX_W'(151), di: DI_W'(49), rcp: RCP_W'(768056)},
        '{lo: BP_W'(1501), ilo: IDX_W'(201), di: DI_W'(99), rcp: RCP_W'(537409)},
        '{lo: BP_W'(2501), ilo: IDX_W'(301), di: DI_W'(99), rcp: RCP_W'(537409)},
        '{lo: BP_W'(3501), ilo: IDX_W'(401), di: DI_W'(99), rcp: RCP_W'(358153)}
    };

    localparam t_tab PM10_TAB = '{
        '{lo: BP_W'(0),    ilo: IDX_W'(0),   di: DI_W'(50), rcp: RCP_W'(1073742)},
        '{lo: BP_W'(501),  ilo: IDX_W'(51),  di: DI_W'(49), rcp: RCP_W'(537409)},
        '{lo: BP_W'(1501), ilo: IDX_W'(101), di: DI_W'(49), rcp: RCP_W'(537409)},
        '{lo: BP_W'(2501), ilo: IDX_W'(151), di: DI_W'(49), rcp: RCP_W'(537409)},
        '{lo: BP_W'(3501), ilo: IDX_W'(201), di: DI_W'(99), rcp: RCP_W'(768056)},
        '{lo: BP_W'(4201), ilo: IDX_W'(301), di: DI_W'(99), rcp: RCP_W'(671929)},
        '{lo: BP_W'(5001), ilo: IDX_W'(401), di: DI_W'(99), rcp: RCP_W'(537409)}
    };

    localparam logic [BP_W-1:0] PM25_TOP = BP_W'(5000);
    localparam logic [BP_W-1:0] PM10_TOP = BP_W'(6000);

    function automatic t_seg seg_get(input bit tab, input logic [ROW_W-1:0] row);
        t_seg s;
        s = '0;
        if (row < ROW_W'(ROWS)) begin
            if (tab == TAB_PM10) begin
                s = PM10_TAB[row];
            end else begin
                s = PM25_TAB[row];
            end
        end
        return s;
    endfunction

    function automatic logic [BP_W-1:0] top_get(input bit tab);
        return (tab == TAB_PM10) ? PM10_TOP : PM25_TOP;
    endfunction

endpackage
`default_nettype wire

### hdl/vn_aqi_pm_interpolator.sv
// Top level of the particulate AQI interpolator: two pollutant lanes and a merge stage.
// Depends on aqi_pkg, aqi_lane and aqi_merge.
//
// A request (one PM2.5 and one PM10 concentration in tenths of ug/m3) is taken on
// every cycle with start high; busy never rises, so one request per cycle is
// sustained. Each result appears five cycles later, on o_valid for a single cycle,
// and must be captured then. The latency is set by the lane pipeline: segment
// search, span product, reciprocal multiply, index add, then the merge register.
`default_nettype none
module vn_aqi_pm_interpolator #(
    parameter int CONC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [CONC_BITS-1:0]      i_pm25_tenths,
    input  logic [CONC_BITS-1:0]      i_pm10_tenths,
    output logic                      o_valid,
    output logic [aqi_pkg::IDX_W-1:0] o_index_pm25,
    output logic [aqi_pkg::IDX_W-1:0] o_index_pm10,
    output logic [aqi_pkg::IDX_W-1:0] o_index_total
);
    import aqi_pkg::*;

    localparam int LAT = 5;

    logic [LAT-1:0] r_vld, n_vld;
    t_idx_pair      pair;

    assign busy  = 1'b0;
    assign n_vld = {r_vld[LAT-2:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    aqi_lane #(.CONC_BITS(CONC_BITS), .TAB(TAB_PM25)) u_lane_pm25 (
        .i_clk   (i_clk),
        .i_conc  (i_pm25_tenths),
        .o_index (pair.pm25)
    );

    aqi_lane #(.CONC_BITS(CONC_BITS), .TAB(TAB_PM10)) u_lane_pm10 (
        .i_clk   (i_clk),
        .i_conc  (i_pm10_tenths),
        .o_index (pair.pm10)
    );

    aqi_merge u_merge (
        .i_clk         (i_clk),
        .i_pair        (pair),
        .o_index_pm25  (o_index_pm25),
        .o_index_pm10  (o_index_pm10),
        .o_index_total (o_index_total)
    );

    assign o_valid = r_vld[LAT-1];

endmodule
`default_nettype wire

### hdl/aqi_lane.sv
// One pollutant lane: segment search, span product, reciprocal divide, offset add.
// Depends on aqi_pkg for the breakpoint tables and widths.
`default_nettype none
module aqi_lane #(
    parameter int CONC_BITS = 16,
    parameter bit TAB       = 1'b0
) (
    input  logic                        i_clk,
    input  logic [CONC_BITS-1:0]        i_conc,
    output logic [aqi_pkg::IDX_W-1:0]   o_index
);
    import aqi_pkg::*;

    logic [ROW_W-1:0] n_row;
    logic [OFF_W-1:0] n_off;
    logic             n_above;
    t_seg             seg_a;
    t_seg             seg_k;

    logic [ROW_W-1:0] r_row_a, r_row_b, r_row_c;
    logic [OFF_W-1:0] r_off_a;
    logic             r_above_a, r_above_b, r_above_c;
    logic [NUM_W-1:0] n_num, r_num;
    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]   n_q, r_q;
    t_seg             seg_b, seg_c, seg_d;
    logic [IDX_W-1:0] n_index, r_index;

    // segment search: rows are contiguous, so the last lo bound passed wins
    always_comb begin
        n_row = '0;
        seg_k = '0;
        for (int k = 1; k < ROWS; k++) begin
            seg_k = seg_get(TAB, ROW_W'(k));
            if (i_conc >= CONC_BITS'(seg_k.lo)) begin
                n_row = ROW_W'(k);
            end
        end
        n_above = i_conc > CONC_BITS'(top_get(TAB));
        seg_a   = seg_get(TAB, n_row);
        n_off   = OFF_W'(i_conc[BP_W-1:0] - seg_a.lo);
    end

    assign seg_b = seg_get(TAB, r_row_a);
    assign n_num = NUM_W'(seg_b.di) * NUM_W'(r_off_a);

    assign seg_c = seg_get(TAB, r_row_b);
    assign prod  = PROD_W'(r_num) * PROD_W'(seg_c.rcp);
    assign n_q   = prod[SHIFT+Q_W-1:SHIFT];

    assign seg_d   = seg_get(TAB, r_row_c);
    assign n_index = r_above_c ? TOP_INDEX : seg_d.ilo + IDX_W'(r_q);

    always_ff @(posedge i_clk) begin
        r_row_a   <= n_row;
        r_off_a   <= n_off;
        r_above_a <= n_above;
        r_row_b   <= r_row_a;
        r_above_b <= r_above_a;
        r_num     <= n_num;
        r_row_c   <= r_row_b;
        r_above_c <= r_above_b;
        r_q       <= n_q;
        r_index   <= n_index;
    end

    assign o_index = r_index;

endmodule
`default_nettype wire

### hdl/aqi_merge.sv
// Merge stage: registers both sub-indices and the larger of the two.
// Depends on aqi_pkg for the index pair type.
`default_nettype none
module aqi_merge (
    input  logic                      i_clk,
    input  aqi_pkg::t_idx_pair        i_pair,
    output logic [aqi_pkg::IDX_W-1:0] o_index_pm25,
    output logic [aqi_pkg::IDX_W-1:0] o_index_pm10,
    output logic [aqi_pkg::IDX_W-1:0] o_index_total
);
    import aqi_pkg::*;

    logic [IDX_W-1:0] r_pm25, r_pm10, r_total, n_total;

    assign n_total = (i_pair.pm25 > i_pair.pm10) ? i_pair.pm25 : i_pair.pm10;

    always_ff @(posedge i_clk) begin
        r_pm25  <= i_pair.pm25;
        r_pm10  <= i_pair.pm10;
        r_total <= n_total;
    end

    assign o_index_pm25  = r_pm25;
    assign o_index_pm10  = r_pm10;
    assign o_index_total = r_total;

endmodule
`default_nettype wire

### hdl/aqi_checker.sv
// Port-level checks for the particulate AQI interpolator, bound to the top level.
// Depends on aqi_pkg for the index width and top index.
`default_nettype none
module aqi_checker #(
    parameter int CONC_BITS = 16
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [CONC_BITS-1:0]      i_pm25_tenths,
    input logic [CONC_BITS-1:0]      i_pm10_tenths,
    input logic                      o_valid,
    input logic [aqi_pkg::IDX_W-1:0] o_index_pm25,
    input logic [aqi_pkg::IDX_W-1:0] o_index_pm10,
    input logic [aqi_pkg::IDX_W-1:0] o_index_total
);
    import aqi_pkg::*;

    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_valid)
        else $error("request without result five cycles later");

    a_total_is_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_index_total == ((o_index_pm25 > o_index_pm10) ?
                                       o_index_pm25 : o_index_pm10)))
        else $error("total index is not the larger sub-index");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_index_pm25 <= TOP_INDEX && o_index_pm10 <= TOP_INDEX))
        else $error("sub-index above top of scale");

    a_low_pm25: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_pm25_tenths <= CONC_BITS'(250))
            |-> ##5 (o_index_pm25 <= IDX_W'(50)))
        else $error("first PM2.5 segment gave an index above 50");

endmodule

bind vn_aqi_pm_interpolator aqi_checker #(.CONC_BITS(CONC_BITS)) u_aqi_checker (.*);
`default_nettype wire
